>>> design/top3_disjoint_segment_register_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the three-slot disjoint segment register
// Shared property forms, clocked on clk and disabled during rst.
// ----------------------------------------------------------------------------
`ifndef TOP3_DISJOINT_SEGMENT_REGISTER_DEFINES_SVH
`define TOP3_DISJOINT_SEGMENT_REGISTER_DEFINES_SVH

// A condition that holds at every clock edge out of reset.
`define TDSR_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// A trigger that forces a condition in the cycle after it.
`define TDSR_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> design/tdsr_pkg.sv
// ----------------------------------------------------------------------------
// Package for the three-slot disjoint segment register
// Slot and word types, item codes and the segment intersection test.
// ----------------------------------------------------------------------------
package tdsr_pkg;

  localparam int SLOT_N   = 3;
  localparam int SCORE_W  = 24;
  localparam int COORD_W  = 32;
  localparam int TOTAL_W  = 26;

  localparam logic [COORD_W-1:0] COORDS_EMPTY = '1;

  typedef enum logic {
    KIND_CLEAR = 1'b0,
    KIND_OFFER = 1'b1
  } kind_t;

  typedef struct packed {
    logic [SCORE_W-1:0] score;
    logic [COORD_W-1:0] coords;
  } slot_t;

  // One registered input word.
  typedef struct packed {
    kind_t              kind;
    logic [SCORE_W-1:0] score;
    logic [COORD_W-1:0] coords;
  } item_t;

  // Coordinates are packed QB QE PB PE, QB in the top byte.
  function automatic logic seg_overlap(logic [COORD_W-1:0] a, logic [COORD_W-1:0] b);
    logic [7:0] qe_min;
    logic [7:0] qb_max;
    logic [7:0] pe_min;
    logic [7:0] pb_max;
    qe_min = (a[23:16] < b[23:16]) ? a[23:16] : b[23:16];
    qb_max = (a[31:24] > b[31:24]) ? a[31:24] : b[31:24];
    pe_min = (a[7:0] < b[7:0]) ? a[7:0] : b[7:0];
    pb_max = (a[15:8] > b[15:8]) ? a[15:8] : b[15:8];
    return (qe_min >= qb_max) || (pe_min >= pb_max);
  endfunction

endpackage

>>> design/top3_disjoint_segment_register.sv
// A taken word moves from the input register into the slot registers. Throughput:
// one word per cycle when no result is stalled; the slot registers are read and
// rewritten in a single pass of the update logic, which also feeds the result ports.
// Reset (rst, synchronous) empties all slots: scores 0, coordinates all 255,
// and drops any word in flight.
// ----------------------------------------------------------------------------
// Three-slot disjoint segment register
// Keeps the three best mutually disjoint segments and reports them after
// every word.
// ----------------------------------------------------------------------------
`include "top3_disjoint_segment_register_defines.svh"

module top3_disjoint_segment_register (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         kind,
  input  logic [tdsr_pkg::SCORE_W-1:0] seg_score,
  input  logic [7:0]                   query_begin,
  input  logic [7:0]                   query_end,
  input  logic [7:0]                   profile_begin,
  input  logic [7:0]                   profile_end,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [tdsr_pkg::SCORE_W-1:0] best_score,
  output logic [tdsr_pkg::SCORE_W-1:0] second_score,
  output logic [tdsr_pkg::SCORE_W-1:0] third_score,
  output logic [tdsr_pkg::COORD_W-1:0] best_coords,
  output logic [tdsr_pkg::COORD_W-1:0] second_coords,
  output logic [tdsr_pkg::COORD_W-1:0] third_coords,
  output logic [tdsr_pkg::TOTAL_W-1:0] score_total
);

  logic                                   item_valid;
  logic                                   advance;
  tdsr_pkg::item_t                        item;
  tdsr_pkg::slot_t [tdsr_pkg::SLOT_N-1:0] slot;
  tdsr_pkg::slot_t [tdsr_pkg::SLOT_N-1:0] slot_next;
  logic [tdsr_pkg::TOTAL_W-1:0]           total_next;
  logic                                   ranked;
  logic [tdsr_pkg::TOTAL_W-1:0]           slot_sum;
  logic                                   clear_taken;
  logic                                   slots_empty;

  // The slot registers double as the result register, so they change only
  // when the previous result has gone.
  assign advance = item_valid && !(out_valid && out_stall);

  tdsr_input_stage u_input (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .kind          (kind),
    .seg_score     (seg_score),
    .query_begin   (query_begin),
    .query_end     (query_end),
    .profile_begin (profile_begin),
    .profile_end   (profile_end),
    .advance       (advance),
    .item_valid    (item_valid),
    .item          (item)
  );

  tdsr_insert u_insert (
    .item       (item),
    .slots      (slot),
    .slots_next (slot_next)
  );

  assign total_next = tdsr_pkg::TOTAL_W'(slot_next[0].score)
                    + tdsr_pkg::TOTAL_W'(slot_next[1].score)
                    + tdsr_pkg::TOTAL_W'(slot_next[2].score);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid   <= 1'b0;
      score_total <= '0;
      for (int i = 0; i < tdsr_pkg::SLOT_N; i++) begin
        slot[i] <= '{score: '0, coords: tdsr_pkg::COORDS_EMPTY};
      end
    end else if (advance) begin
      out_valid   <= 1'b1;
      score_total <= total_next;
      slot        <= slot_next;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  assign best_score    = slot[0].score;
  assign second_score  = slot[1].score;
  assign third_score   = slot[2].score;
  assign best_coords   = slot[0].coords;
  assign second_coords = slot[1].coords;
  assign third_coords  = slot[2].coords;

  assign ranked      = (slot[0].score >= slot[1].score) && (slot[1].score >= slot[2].score);
  assign slot_sum    = tdsr_pkg::TOTAL_W'(slot[0].score)
                     + tdsr_pkg::TOTAL_W'(slot[1].score)
                     + tdsr_pkg::TOTAL_W'(slot[2].score);
  assign clear_taken = advance && (item.kind == tdsr_pkg::KIND_CLEAR);
  assign slots_empty = (score_total == '0)
                     && (slot[0].coords == tdsr_pkg::COORDS_EMPTY)
                     && (slot[2].coords == tdsr_pkg::COORDS_EMPTY);

  `TDSR_ALWAYS(a_ranked, ranked, "slots out of rank order")
  `TDSR_ALWAYS(a_total, score_total == slot_sum, "score total does not match slots")
  `TDSR_NEXT(a_clear, clear_taken, slots_empty, "clear word left slots filled")
  `TDSR_NEXT(a_hold, out_valid && out_stall, $stable(slot) && out_valid, "stalled result changed")

endmodule

>>> design/tdsr_input_stage.sv
// ----------------------------------------------------------------------------
// Input register
// Captures one word from the input channel and holds it until the slot
// update takes it.
// ----------------------------------------------------------------------------
module tdsr_input_stage (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         kind,
  input  logic [tdsr_pkg::SCORE_W-1:0] seg_score,
  input  logic [7:0]                   query_begin,
  input  logic [7:0]                   query_end,
  input  logic [7:0]                   profile_begin,
  input  logic [7:0]                   profile_end,
  input  logic                         advance,
  output logic                         item_valid,
  output tdsr_pkg::item_t              item
);

  logic take;

  // The register frees up in the same cycle that its word moves on.
  assign in_stall = item_valid && !advance;
  assign take     = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (take) begin
      item_valid <= 1'b1;
    end else if (advance) begin
      item_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      item.kind   <= tdsr_pkg::kind_t'(kind);
      item.score  <= seg_score;
      item.coords <= {query_begin, query_end, profile_begin, profile_end};
    end
  end

endmodule

>>> design/tdsr_insert.sv
// ----------------------------------------------------------------------------
// Slot update logic
// Empties all slots on a clear word. Ranks an offered segment against the three
// slots, rejects or inserts it, and zeroes and compacts lower slots that it intersects.
// ----------------------------------------------------------------------------
module tdsr_insert (
  input  tdsr_pkg::item_t                    item,
  input  tdsr_pkg::slot_t [tdsr_pkg::SLOT_N-1:0] slots,
  output tdsr_pkg::slot_t [tdsr_pkg::SLOT_N-1:0] slots_next
);

  tdsr_pkg::slot_t seg;
  logic            ge0;
  logic            ge1;
  logic            ge2;
  logic            ov0;
  logic            ov1;
  logic            kill1;
  logic            kill2;

  assign seg = '{score: item.score, coords: item.coords};
  assign ge0 = item.score >= slots[0].score;
  assign ge1 = item.score >= slots[1].score;
  assign ge2 = item.score >= slots[2].score;
  assign ov0 = tdsr_pkg::seg_overlap(item.coords, slots[0].coords);
  assign ov1 = tdsr_pkg::seg_overlap(item.coords, slots[1].coords);

  // When the segment takes the top, the old slots 0 and 1 shift down and
  // lose their score if they intersect it.
  assign kill1 = (slots[0].score == '0) || ov0;
  assign kill2 = (slots[1].score == '0) || ov1;

  always_comb begin
    slots_next = slots;
    if (item.kind == tdsr_pkg::KIND_CLEAR) begin
      for (int i = 0; i < tdsr_pkg::SLOT_N; i++) begin
        slots_next[i] = '{score: '0, coords: tdsr_pkg::COORDS_EMPTY};
      end
    end else if (item.score != '0) begin
      priority if (ge0) begin
        slots_next[0] = seg;
        if (kill1) begin
          // Slot 1 empties, so the old slot 1 moves up and slot 2 takes the old slot 1
          // coordinates with a zero score.
          slots_next[1].score  = kill2 ? '0 : slots[1].score;
          slots_next[1].coords = slots[1].coords;
          slots_next[2].score  = '0;
          slots_next[2].coords = slots[1].coords;
        end else begin
          slots_next[1]        = slots[0];
          slots_next[2].score  = kill2 ? '0 : slots[1].score;
          slots_next[2].coords = slots[1].coords;
        end
      end else if (ge1) begin
        if (!ov0) begin
          slots_next[1]        = seg;
          slots_next[2].score  = ov1 ? '0 : slots[1].score;
          slots_next[2].coords = slots[1].coords;
        end
      end else if (ge2) begin
        if (!ov0 && !ov1) begin
          slots_next[2] = seg;
        end
      end else begin
        // A score below all three slots leaves them as they are.
        slots_next = slots;
      end
    end
  end

endmodule

>>> verif/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Testbench for the three-slot disjoint segment register
// Drives clear and offer words through the valid/stall handshake. Both sides
// idle at random and the receiver holds off once for a long stretch. A
// scoreboard keeps its own copy of the three ranked slots, predicts the full
// slot report for every accepted word, and compares each report field by field.
// ----------------------------------------------------------------------------
module testbench;

  typedef struct packed {
    logic [tdsr_pkg::SLOT_N-1:0][tdsr_pkg::SCORE_W-1:0] score;
    logic [tdsr_pkg::SLOT_N-1:0][tdsr_pkg::COORD_W-1:0] coords;
    logic [tdsr_pkg::TOTAL_W-1:0]                       total;
  } slot_report_t;

  class slot_board;
    logic [tdsr_pkg::SCORE_W-1:0] score [tdsr_pkg::SLOT_N];
    logic [tdsr_pkg::COORD_W-1:0] coords [tdsr_pkg::SLOT_N];
    slot_report_t                 pending [$];
    int                           errors;

    function new();
      errors = 0;
      empty_slots();
    endfunction

    function void empty_slots();
      for (int i = 0; i < tdsr_pkg::SLOT_N; i++) begin
        score[i]  = '0;
        coords[i] = tdsr_pkg::COORDS_EMPTY;
      end
    endfunction

    // Segments clash when their query ranges or their profile ranges share a point.
    function bit crosses(logic [tdsr_pkg::COORD_W-1:0] a, logic [tdsr_pkg::COORD_W-1:0] b);
      logic [7:0] q_hi;
      logic [7:0] q_lo;
      logic [7:0] p_hi;
      logic [7:0] p_lo;
      q_hi = (a[23:16] < b[23:16]) ? a[23:16] : b[23:16];
      q_lo = (a[31:24] > b[31:24]) ? a[31:24] : b[31:24];
      p_hi = (a[7:0] < b[7:0]) ? a[7:0] : b[7:0];
      p_lo = (a[15:8] > b[15:8]) ? a[15:8] : b[15:8];
      return (q_hi >= q_lo) || (p_hi >= p_lo);
    endfunction

    function void move_slot(int to, int from);
      score[to]  = score[from];
      coords[to] = coords[from];
    endfunction

    function void rank_segment(logic [tdsr_pkg::SCORE_W-1:0] s,
                               logic [tdsr_pkg::COORD_W-1:0] c);
      if (s == '0) return;
      if (score[0] <= s) begin
        move_slot(2, 1);
        move_slot(1, 0);
        score[0]  = s;
        coords[0] = c;
        if (score[1] != '0 && crosses(coords[0], coords[1])) score[1] = '0;
        if (score[2] != '0 && crosses(coords[0], coords[2])) score[2] = '0;
        // A zeroed second slot pulls the third one up; stale coordinates move too.
        if (score[1] == '0) begin
          move_slot(1, 2);
          score[2] = '0;
        end
      end else if (score[1] <= s) begin
        if (crosses(c, coords[0])) return;
        move_slot(2, 1);
        score[1]  = s;
        coords[1] = c;
        if (crosses(coords[1], coords[2])) score[2] = '0;
      end else if (score[2] <= s) begin
        if (crosses(c, coords[0]) || crosses(c, coords[1])) return;
        score[2]  = s;
        coords[2] = c;
      end
    endfunction

    function void note_word(logic k, logic [tdsr_pkg::SCORE_W-1:0] s,
                            logic [tdsr_pkg::COORD_W-1:0] c);
      slot_report_t r;
      if (k == tdsr_pkg::KIND_CLEAR) empty_slots();
      else rank_segment(s, c);
      r.total = '0;
      for (int i = 0; i < tdsr_pkg::SLOT_N; i++) begin
        r.score[i]  = score[i];
        r.coords[i] = coords[i];
        r.total     = r.total + tdsr_pkg::TOTAL_W'(score[i]);
      end
      pending.push_back(r);
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
        errors++;
      end
    endfunction

    function void check_report(slot_report_t got);
      slot_report_t want;
      if (pending.size() == 0) begin
        $error("result word with no expectation pending");
        errors++;
        return;
      end
      want = pending.pop_front();
      compare_field("best_score", 32'(want.score[0]), 32'(got.score[0]));
      compare_field("second_score", 32'(want.score[1]), 32'(got.score[1]));
      compare_field("third_score", 32'(want.score[2]), 32'(got.score[2]));
      compare_field("best_coords", want.coords[0], got.coords[0]);
      compare_field("second_coords", want.coords[1], got.coords[1]);
      compare_field("third_coords", want.coords[2], got.coords[2]);
      compare_field("score_total", 32'(want.total), 32'(got.total));
    endfunction

    function int pending_count();
      return pending.size();
    endfunction
  endclass

  logic                         clk = 1'b0;
  logic                         rst = 1'b1;
  logic                         in_valid = 1'b0;
  logic                         in_stall;
  logic                         kind = tdsr_pkg::KIND_CLEAR;
  logic [tdsr_pkg::SCORE_W-1:0] seg_score = '0;
  logic [7:0]                   query_begin = '0;
  logic [7:0]                   query_end = '0;
  logic [7:0]                   profile_begin = '0;
  logic [7:0]                   profile_end = '0;
  logic                         out_valid;
  logic                         out_stall = 1'b0;
  logic [tdsr_pkg::SCORE_W-1:0] best_score;
  logic [tdsr_pkg::SCORE_W-1:0] second_score;
  logic [tdsr_pkg::SCORE_W-1:0] third_score;
  logic [tdsr_pkg::COORD_W-1:0] best_coords;
  logic [tdsr_pkg::COORD_W-1:0] second_coords;
  logic [tdsr_pkg::COORD_W-1:0] third_coords;
  logic [tdsr_pkg::TOTAL_W-1:0] score_total;

  bit        no_idle = 1'b0;
  bit        hold_request = 1'b0;
  slot_board board;

  top3_disjoint_segment_register dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .kind          (kind),
    .seg_score     (seg_score),
    .query_begin   (query_begin),
    .query_end     (query_end),
    .profile_begin (profile_begin),
    .profile_end   (profile_end),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .best_score    (best_score),
    .second_score  (second_score),
    .third_score   (third_score),
    .best_coords   (best_coords),
    .second_coords (second_coords),
    .third_coords  (third_coords),
    .score_total   (score_total)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Called at a rising edge; returns at the edge where the word is taken.
  task automatic push_word(input logic k, input logic [tdsr_pkg::SCORE_W-1:0] s,
                           input logic [7:0] qb, input logic [7:0] qe,
                           input logic [7:0] pb, input logic [7:0] pe);
    while (!no_idle && $urandom_range(0, 99) < 21) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    kind          <= k;
    seg_score     <= s;
    query_begin   <= qb;
    query_end     <= qe;
    profile_begin <= pb;
    profile_end   <= pe;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    board.note_word(k, s, {qb, qe, pb, pe});
  endtask

  // Mostly short ranges so that slots fill and clash; sometimes any bytes at all.
  function automatic void pick_span(output logic [7:0] lo, output logic [7:0] hi);
    if ($urandom_range(0, 99) < 85) begin
      lo = 8'($urandom_range(0, 255));
      hi = lo + 8'($urandom_range(0, 12));
    end else begin
      lo = 8'($urandom);
      hi = 8'($urandom);
    end
  endfunction

  initial begin : word_side
    logic [tdsr_pkg::SCORE_W-1:0] s;
    logic [7:0]                   qb;
    logic [7:0]                   qe;
    logic [7:0]                   pb;
    logic [7:0]                   pe;
    int                           pick;
    board = new();
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    push_word(tdsr_pkg::KIND_CLEAR, '1, 8'hff, 8'hff, 8'hff, 8'hff);
    push_word(tdsr_pkg::KIND_OFFER, '0, 8'h00, 8'h00, 8'h00, 8'h00);
    push_word(tdsr_pkg::KIND_OFFER, 24'd100, 8'd10, 8'd20, 8'd10, 8'd20);
    push_word(tdsr_pkg::KIND_OFFER, 24'd50, 8'd30, 8'd40, 8'd30, 8'd40);
    push_word(tdsr_pkg::KIND_OFFER, 24'd20, 8'd50, 8'd60, 8'd50, 8'd60);
    push_word(tdsr_pkg::KIND_OFFER, 24'd10, 8'd90, 8'd95, 8'd90, 8'd95);
    push_word(tdsr_pkg::KIND_OFFER, 24'd20, 8'd70, 8'd80, 8'd70, 8'd80);
    push_word(tdsr_pkg::KIND_OFFER, 24'd50, 8'd15, 8'd16, 8'd90, 8'd95);
    push_word(tdsr_pkg::KIND_OFFER, 24'd60, 8'd35, 8'd36, 8'd100, 8'd101);
    push_word(tdsr_pkg::KIND_OFFER, 24'd200, 8'd12, 8'd13, 8'd200, 8'd210);
    push_word(tdsr_pkg::KIND_OFFER, 24'hffffff, 8'd0, 8'd0, 8'd0, 8'd0);
    push_word(tdsr_pkg::KIND_OFFER, 24'hffffff, 8'd255, 8'd255, 8'd255, 8'd255);
    push_word(tdsr_pkg::KIND_OFFER, 24'd500, 8'd200, 8'd100, 8'd150, 8'd140);
    push_word(tdsr_pkg::KIND_OFFER, 24'd1, 8'd0, 8'd0, 8'd0, 8'd0);
    push_word(tdsr_pkg::KIND_CLEAR, '0, 8'd0, 8'd0, 8'd0, 8'd0);
    push_word(tdsr_pkg::KIND_OFFER, 24'hffffff, 8'd0, 8'd255, 8'd0, 8'd255);
    push_word(tdsr_pkg::KIND_OFFER, 24'hffffff, 8'd1, 8'd2, 8'd1, 8'd2);
    push_word(tdsr_pkg::KIND_OFFER, 24'hfffffe, 8'd10, 8'd20, 8'd10, 8'd20);
    push_word(tdsr_pkg::KIND_OFFER, 24'hfffffd, 8'd30, 8'd40, 8'd30, 8'd40);
    push_word(tdsr_pkg::KIND_OFFER, 24'hfffffd, 8'd50, 8'd60, 8'd50, 8'd60);

    for (int n = 0; n < 1800; n++) begin
      if (n == 300) hold_request <= 1'b1;
      if (n == 700) no_idle <= 1'b1;
      if (n == 1000) no_idle <= 1'b0;
      if (n == 1300) begin
        // Let the block drain completely before carrying on.
        in_valid <= 1'b0;
        @(posedge clk);
        while (board.pending_count() != 0) @(posedge clk);
      end
      pick_span(qb, qe);
      pick_span(pb, pe);
      pick = $urandom_range(0, 99);
      if (pick < 5) s = '0;
      else if (pick < 30) begin
        s = tdsr_pkg::SCORE_W'(board.score[2'($urandom_range(0, 2))]
                               + $urandom_range(0, 2) - 1);
      end
      else if (pick < 40) s = tdsr_pkg::SCORE_W'($urandom);
      else if (pick < 45) s = '1;
      else s = tdsr_pkg::SCORE_W'($urandom_range(1, 4000));
      if ($urandom_range(0, 99) < 3) push_word(tdsr_pkg::KIND_CLEAR, s, qb, qe, pb, pe);
      else push_word(tdsr_pkg::KIND_OFFER, s, qb, qe, pb, pe);
    end

    in_valid <= 1'b0;
    while (board.pending_count() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
    if (board.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin : result_side
    int           hold_left;
    bit           hold_served;
    slot_report_t seen;
    hold_left   = 0;
    hold_served = 1'b0;
    wait (!rst);
    forever begin
      @(posedge clk);
      if (out_valid && !out_stall) begin
        seen.score  = {third_score, second_score, best_score};
        seen.coords = {third_coords, second_coords, best_coords};
        seen.total  = score_total;
        board.check_report(seen);
      end
      // One long hold-off so that the block backs up and stalls its input.
      if (hold_request && !hold_served) begin
        hold_served = 1'b1;
        hold_left   = 120;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= !no_idle && ($urandom_range(0, 99) < 21);
      end
    end
  end

  initial begin : watchdog
    #3000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
